[design/mrr_pkg.sv]
// Shared constants and types for the read-registers responder.
package mrr_pkg;

    // Default bank depth and read-count limit
    localparam int MEM_DEPTH_DEF = 256;
    localparam int MAX_REGS      = 29;

    // Field widths
    localparam int ADDR_W  = 8;
    localparam int FUNC_W  = 8;
    localparam int START_W = 8;
    localparam int COUNT_W = 5;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;

    // CRC-16/MODBUS, reflected form
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Which byte of the response frame is in flight
    typedef enum logic [2:0] {
        K_ADDR   = 3'd0,
        K_FUNC   = 3'd1,
        K_COUNT  = 3'd2,
        K_HI     = 3'd3,
        K_LO     = 3'd4,
        K_CRC_LO = 3'd5,
        K_CRC_HI = 3'd6
    } byte_kind_t;

    // Control from the sequencer to the serial CRC unit
    typedef struct packed {
        logic init;
        logic load;
    } crc_ctl_t;

endpackage

[design/mrr_if.sv]
// Request and response channel interfaces for the read-registers responder.
interface mrr_req_if
    import mrr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [ADDR_W-1:0]    slave_address;
    logic [FUNC_W-1:0]    function_code;
    logic [START_W-1:0]   start_index;
    logic [COUNT_W-1:0]   register_count;
    logic [WORD_W-1:0]    write_word;

    modport source (
        output valid, cmd, slave_address, function_code, start_index,
               register_count, write_word,
        input  ready
    );
    modport sink (
        input  valid, cmd, slave_address, function_code, start_index,
               register_count, write_word,
        output ready
    );
endinterface

interface mrr_rsp_if
    import mrr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] tx_byte;
    logic              frame_last;

    modport source (
        output valid, tx_byte, frame_last,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, frame_last,
        output ready
    );
endinterface

[design/mrr_crc.sv]
// Bit-serial CRC-16/MODBUS unit: folds in one byte, one bit at a time.
module mrr_crc
    import mrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  crc_ctl_t          ctl,
    input  logic [BYTE_W-1:0] data_in,
    output logic [15:0]       crc,
    output logic              busy
);

    logic [15:0]       crc_reg;
    logic [15:0]       crc_next;
    logic [BYTE_W-1:0] sh_reg;
    logic [BYTE_W-1:0] sh_next;
    logic [3:0]        cnt_reg;
    logic [3:0]        cnt_next;
    logic              fb;

    assign fb = crc_reg[0] ^ sh_reg[0];

    // Reload, take a byte, or shift one bit through the polynomial
    always_comb
    begin
        crc_next = crc_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (ctl.init)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctl.load)
        begin
            sh_next  = data_in;
            cnt_next = 4'(BYTE_W);
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = (crc_reg >> 1) ^ (fb ? CRC_POLY : 16'h0000);
            sh_next  = sh_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            cnt_reg <= 4'd0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold the byte being folded in
    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != 4'd0);

endmodule

[design/mrr_bank.sv]
// Holding-register bank: one write port, one registered read port.
module mrr_bank
    import mrr_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF,
    parameter int IDX_W     = $clog2(MEM_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [MEM_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Store one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/modbus_read_registers_responder.sv]
// Read holding registers responder: register bank, bit-serial CRC and frame sequencer.
// Write beat: accepted in idle, index reduced when MEM_DEPTH < 256, then written.
// Read beat: frame of 5 + 2N bytes, each sent under the output ready handshake
// (preceded by index reduction when MEM_DEPTH < 256).
// Bytes before the CRC fold in one bit per cycle; that and rsp.ready set the pace.
// One request at a time; reset returns the sequencer to idle and the CRC to 0xFFFF.
module modbus_read_registers_responder
    import mrr_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    mrr_req_if.sink    req,
    mrr_rsp_if.source  rsp
);

    localparam int               IDX_W       = $clog2(MEM_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(MEM_DEPTH - 1);
    localparam bit               NEED_MOD    = (MEM_DEPTH < 256);
    localparam logic [8:0]       DEPTH_SMALL = NEED_MOD ? 9'(MEM_DEPTH) : 9'd0;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_REDUCE = 7'b0000010,
        S_ROUTE  = 7'b0000100,
        S_FETCH  = 7'b0001000,
        S_LOAD   = 7'b0010000,
        S_CRC    = 7'b0100000,
        S_SEND   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    byte_kind_t          kind_reg, kind_next;
    logic [2:0]          step_reg, step_next;
    logic [COUNT_W-1:0]  remain_reg, remain_next;
    logic                cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [START_W-1:0]  red_reg, red_next;
    logic [WORD_W-1:0]   wword_reg, wword_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BYTE_W-1:0]   lo_reg, lo_next;
    logic [BYTE_W-1:0]   tx_reg, tx_next;
    logic                last_reg, last_next;

    logic [15:0]         sub_val;
    logic [IDX_W-1:0]    route_idx;
    logic [BYTE_W-1:0]   cur_byte;
    logic [COUNT_W-1:0]  clamped;

    crc_ctl_t            crc_ctl;
    logic [15:0]         crc_val;
    logic                crc_busy;
    logic                wr_en;
    logic                rd_en;
    logic [WORD_W-1:0]   rd_data;

    mrr_crc u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (crc_ctl),
        .data_in (cur_byte),
        .crc     (crc_val),
        .busy    (crc_busy)
    );

    mrr_bank #(
        .MEM_DEPTH (MEM_DEPTH),
        .IDX_W     (IDX_W)
    ) u_bank (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (route_idx),
        .wr_data (wword_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign sub_val   = {7'd0, DEPTH_SMALL} << step_reg;
    assign route_idx = IDX_W'(red_reg);
    assign clamped   = (req.register_count > COUNT_W'(MAX_REGS)) ?
                       COUNT_W'(MAX_REGS) : req.register_count;

    // Pick the frame byte for the current position
    always_comb
    begin
        case (kind_reg)
            K_ADDR:   cur_byte = addr_reg;
            K_FUNC:   cur_byte = func_reg;
            K_COUNT:  cur_byte = BYTE_W'({remain_reg, 1'b0});
            K_HI:     cur_byte = rd_data[15:8];
            K_LO:     cur_byte = lo_reg;
            K_CRC_LO: cur_byte = crc_val[7:0];
            K_CRC_HI: cur_byte = crc_val[15:8];
            default:  cur_byte = '0;
        endcase
    end

    // Sequence request handling and frame bytes
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        step_next   = step_reg;
        remain_next = remain_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        func_next   = func_reg;
        red_next    = red_reg;
        wword_next  = wword_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        tx_next     = tx_reg;
        last_next   = last_reg;
        crc_ctl     = '0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    addr_next   = req.slave_address;
                    func_next   = req.function_code;
                    red_next    = req.start_index;
                    wword_next  = req.write_word;
                    remain_next = clamped;
                    step_next   = 3'd7;
                    state_next  = NEED_MOD ? S_REDUCE : S_ROUTE;
                end
            end
            S_REDUCE:
            begin
                // Restoring reduction of the start index by the depth
                if ({8'd0, red_reg} >= sub_val)
                begin
                    red_next = red_reg - sub_val[7:0];
                end
                if (step_reg == 3'd0)
                begin
                    state_next = S_ROUTE;
                end
                else
                begin
                    step_next = step_reg - 3'd1;
                end
            end
            S_ROUTE:
            begin
                idx_next = route_idx;
                if (cmd_reg == CMD_WRITE)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    crc_ctl.init = 1'b1;
                    kind_next    = K_ADDR;
                    state_next   = S_LOAD;
                end
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                tx_next   = cur_byte;
                last_next = (kind_reg == K_CRC_HI);
                if (kind_reg == K_HI)
                begin
                    lo_next = rd_data[7:0];
                end
                if (kind_reg == K_CRC_LO || kind_reg == K_CRC_HI)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    crc_ctl.load = 1'b1;
                    state_next   = S_CRC;
                end
            end
            S_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (rsp.ready)
                begin
                    state_next = S_LOAD;
                    case (kind_reg)
                        K_ADDR:  kind_next = K_FUNC;
                        K_FUNC:  kind_next = K_COUNT;
                        K_COUNT:
                        begin
                            if (remain_reg == '0)
                            begin
                                kind_next = K_CRC_LO;
                            end
                            else
                            begin
                                kind_next  = K_HI;
                                state_next = S_FETCH;
                            end
                        end
                        K_HI:    kind_next = K_LO;
                        K_LO:
                        begin
                            remain_next = remain_reg - 1'b1;
                            if (remain_reg == COUNT_W'(1))
                            begin
                                kind_next = K_CRC_LO;
                            end
                            else
                            begin
                                kind_next  = K_HI;
                                idx_next   = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        K_CRC_LO: kind_next = K_CRC_HI;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= K_ADDR;
            step_reg   <= 3'd0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            step_reg   <= step_next;
            remain_reg <= remain_next;
        end
    end

    // Hold request fields and the outgoing beat
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        addr_reg  <= addr_next;
        func_reg  <= func_next;
        red_reg   <= red_next;
        wword_reg <= wword_next;
        idx_reg   <= idx_next;
        lo_reg    <= lo_next;
        tx_reg    <= tx_next;
        last_reg  <= last_next;
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = (state_reg == S_SEND);
    assign rsp.tx_byte    = tx_reg;
    assign rsp.frame_last = last_reg;

endmodule
